### src/ascl_pkg.sv
// Shared types, constants and radius table for the atom set clash test.
// Used by ascl_ctrl, ascl_dp and atom_set_clash_test; depends on nothing.
`default_nettype none

package ascl_pkg;

  // Reference store geometry
  localparam int MAX_ATOMS = 256;
  localparam int ADDR_W    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ATOMS + 1);

  // Field widths
  localparam int MODE_W  = 2;
  localparam int COORD_W = 16;
  localparam int EL_W    = 3;
  localparam int HELD_W  = 9;
  localparam int RAD_W   = 9;   // sum of two radii, 0.01 A units
  localparam int ATOM_W  = 3 * COORD_W + EL_W;

  // Squared distance is in 2^-16 A^2, radii in 0.01 A: d2 * 10000 vs rs^2 * 65536
  localparam int DIST_SCALE = 10000;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PROBE = 2'd2;

  // Element codes
  localparam logic [EL_W-1:0] EL_C = 3'd0;
  localparam logic [EL_W-1:0] EL_N = 3'd1;
  localparam logic [EL_W-1:0] EL_O = 3'd2;
  localparam logic [EL_W-1:0] EL_H = 3'd3;
  localparam logic [EL_W-1:0] EL_S = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;    // empty the store, clear overflow flag
    logic load;     // append request atom
    logic capture;  // latch probe atom, rewind scan address
    logic issue;    // read next stored atom into the pipeline
    logic finish;   // probe complete, report if last
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic count_zero;  // store empty
    logic last_addr;   // scan address is the final stored entry
    logic pipe_busy;   // compare pipeline holds an entry
  } sts_t;

  // Van der Waals radius in 0.01 A units
  function automatic logic [RAD_W-2:0] radius(input logic [EL_W-1:0] el);
    logic [RAD_W-2:0] r;
    case (el)
      EL_C:    r = 8'd170;
      EL_N:    r = 8'd155;
      EL_O:    r = 8'd152;
      EL_H:    r = 8'd109;
      EL_S:    r = 8'd180;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### src/ascl_ctrl.sv
// Request sequencer for the atom set clash test.
// Depends on ascl_pkg (cmd_t, sts_t, mode codes).
`default_nettype none

module ascl_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [ascl_pkg::MODE_W-1:0] in_mode,
  input  wire ascl_pkg::sts_t             sts,
  output ascl_pkg::cmd_t                  cmd,
  output logic                            busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            ascl_pkg::MODE_CLEAR: cmd.clear = 1'b1;
            ascl_pkg::MODE_LOAD:  cmd.load  = 1'b1;
            ascl_pkg::MODE_PROBE: begin
              cmd.capture = 1'b1;
              state_nxt   = sts.count_zero ? S_DRAIN : S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.last_addr) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !sts.pipe_busy)
    else $error("pipeline active while idle");

  a_probe_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == ascl_pkg::MODE_PROBE) |=> busy)
    else $error("probe request did not raise busy");

  a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !sts.pipe_busy)
    else $error("probe finished with compares in flight");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !sts.count_zero)
    else $error("scan running over an empty store");
`endif

endmodule

`default_nettype wire

### src/ascl_dp.sv
// Datapath: reference atom store, four-stage distance compare pipeline,
// sticky flags and result register. Depends on ascl_pkg.
`default_nettype none

module ascl_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ascl_pkg::cmd_t                    cmd,
  output ascl_pkg::sts_t                         sts,
  input  wire logic signed [ascl_pkg::COORD_W-1:0] in_pos_x,
  input  wire logic signed [ascl_pkg::COORD_W-1:0] in_pos_y,
  input  wire logic signed [ascl_pkg::COORD_W-1:0] in_pos_z,
  input  wire logic [ascl_pkg::EL_W-1:0]         in_element,
  input  wire logic                              in_last,
  output logic                                   out_valid,
  output logic                                   out_clash,
  output logic                                   out_overflow,
  output logic [ascl_pkg::HELD_W-1:0]            out_held_atoms
);

  localparam int CW   = ascl_pkg::COORD_W;
  localparam int SQ_W = 2 * CW;
  localparam int D2_W = SQ_W + 2;
  localparam int RS_W = 2 * ascl_pkg::RAD_W;
  localparam int CMP_W = D2_W + 14;

  // Store and counters
  logic [ascl_pkg::ATOM_W-1:0] mem [ascl_pkg::MAX_ATOMS];
  logic [ascl_pkg::CNT_W-1:0]  cnt_r;
  logic [ascl_pkg::ADDR_W-1:0] addr_r;
  logic                        full;
  logic                        dropped_r;

  // Latched probe
  logic signed [CW-1:0]        px_r, py_r, pz_r;
  logic [ascl_pkg::EL_W-1:0]   pel_r;
  logic                        plast_r;

  // Pipeline
  logic                        v1_r, v2_r, v3_r;
  logic [ascl_pkg::ATOM_W-1:0] rd_r;
  logic signed [CW-1:0]        rx, ry, rz;
  logic [ascl_pkg::EL_W-1:0]   rel;
  logic signed [CW:0]          dx, dy, dz;
  logic [CW-1:0]               mx, my, mz;
  logic [SQ_W-1:0]             sqx_r, sqy_r, sqz_r;
  logic [ascl_pkg::RAD_W-1:0]  rs_r;
  logic [D2_W-1:0]             d2_r;
  logic [RS_W-1:0]             rs_sq_r;
  logic [CMP_W-1:0]            d2_scaled;
  logic [CMP_W-1:0]            thresh;
  logic                        hit;
  logic                        clash_r;

  assign full = (cnt_r == ascl_pkg::CNT_W'(ascl_pkg::MAX_ATOMS));

  // Status back to the controller
  assign sts.count_zero = (cnt_r == '0);
  assign sts.last_addr  = ((ascl_pkg::CNT_W'(addr_r) + ascl_pkg::CNT_W'(1)) == cnt_r);
  assign sts.pipe_busy  = v1_r || v2_r || v3_r;

  // Store write port
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[cnt_r[ascl_pkg::ADDR_W-1:0]] <= {in_pos_x, in_pos_y, in_pos_z, in_element};
    end
  end

  // Store read port, registered
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_r <= mem[addr_r];
    end
  end

  // Fill count and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.clear) begin
      cnt_r     <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        dropped_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + ascl_pkg::CNT_W'(1);
      end
    end
  end

  // Scan address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else if (cmd.capture) begin
      addr_r <= '0;
    end else if (cmd.issue) begin
      addr_r <= addr_r + ascl_pkg::ADDR_W'(1);
    end
  end

  // Probe latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r    <= in_pos_x;
      py_r    <= in_pos_y;
      pz_r    <= in_pos_z;
      pel_r   <= in_element;
      plast_r <= in_last;
    end
  end

  // Stage 2: absolute differences and squares, radius sum
  assign {rx, ry, rz, rel} = rd_r;
  assign dx = {px_r[CW-1], px_r} - {rx[CW-1], rx};
  assign dy = {py_r[CW-1], py_r} - {ry[CW-1], ry};
  assign dz = {pz_r[CW-1], pz_r} - {rz[CW-1], rz};
  assign mx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign my = dy[CW] ? CW'(-dy) : dy[CW-1:0];
  assign mz = dz[CW] ? CW'(-dz) : dz[CW-1:0];

  always_ff @(posedge clk) begin
    sqx_r <= SQ_W'(mx) * SQ_W'(mx);
    sqy_r <= SQ_W'(my) * SQ_W'(my);
    sqz_r <= SQ_W'(mz) * SQ_W'(mz);
    rs_r  <= {1'b0, ascl_pkg::radius(pel_r)} + {1'b0, ascl_pkg::radius(rel)};
  end

  // Stage 3: squared distance and squared contact distance
  always_ff @(posedge clk) begin
    d2_r    <= D2_W'(sqx_r) + D2_W'(sqy_r) + D2_W'(sqz_r);
    rs_sq_r <= RS_W'(rs_r) * RS_W'(rs_r);
  end

  // Stage 4: strict overlap test in common units
  assign d2_scaled = CMP_W'(d2_r) * CMP_W'(ascl_pkg::DIST_SCALE);
  assign thresh    = CMP_W'({rs_sq_r, 16'b0});
  assign hit       = (d2_scaled < thresh);

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Sticky clash flag, cleared once a molecule is reported
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clash_r <= 1'b0;
    end else if (cmd.finish && plast_r) begin
      clash_r <= 1'b0;
    end else if (v3_r && hit) begin
      clash_r <= 1'b1;
    end
  end

  // Result strobe and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish && plast_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_clash      <= clash_r;
      out_overflow   <= dropped_r;
      out_held_atoms <= ascl_pkg::HELD_W'(cnt_r);
    end
  end

endmodule

`default_nettype wire

### src/atom_set_clash_test.sv
// Top level of the atom set clash test: controller plus datapath.
// Depends on ascl_pkg, ascl_ctrl and ascl_dp.
//
// Clear and load requests never raise busy. A probe request raises busy
// while the single read port of the reference store feeds one stored atom
// per cycle into a four-stage compare pipeline, which then drains; with an
// empty store the scan is skipped. A probe marked last produces one result,
// strobed by out_valid for one cycle, the first cycle with busy low; the
// receiver has no way to stall it and must take it then. Probes not marked
// last produce no result.
`default_nettype none

module atom_set_clash_test (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [ascl_pkg::MODE_W-1:0]         in_mode,
  input  wire logic signed [ascl_pkg::COORD_W-1:0] in_pos_x,
  input  wire logic signed [ascl_pkg::COORD_W-1:0] in_pos_y,
  input  wire logic signed [ascl_pkg::COORD_W-1:0] in_pos_z,
  input  wire logic [ascl_pkg::EL_W-1:0]           in_element,
  input  wire logic                                in_last,
  output logic                                     out_valid,
  output logic                                     out_clash,
  output logic                                     out_overflow,
  output logic [ascl_pkg::HELD_W-1:0]              out_held_atoms
);

  ascl_pkg::cmd_t cmd;
  ascl_pkg::sts_t sts;

  // Request sequencer
  ascl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Store and compare datapath
  ascl_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_element     (in_element),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_clash      (out_clash),
    .out_overflow   (out_overflow),
    .out_held_atoms (out_held_atoms)
  );

endmodule

`default_nettype wire

### tb/sv/tb_atom_set_clash_test.sv
// Self-checking testbench for atom_set_clash_test: a directed table, then random
// reference sets and probe molecules, each result checked against a table row or predictor.
// Depends on ascl_pkg and the atom_set_clash_test RTL.
`default_nettype none

module tb_atom_set_clash_test;

  // Codes without a package name
  localparam logic [ascl_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [ascl_pkg::EL_W-1:0]   EL_UNK5     = 3'd5;
  localparam logic [ascl_pkg::EL_W-1:0]   EL_UNK6     = 3'd6;
  localparam logic [ascl_pkg::EL_W-1:0]   EL_UNK7     = 3'd7;

  localparam int ITEM_GOAL    = 1900;
  localparam int DRAIN_CYCLES = ascl_pkg::MAX_ATOMS + 40;

  typedef struct packed {
    logic [ascl_pkg::MODE_W-1:0]         mode;
    logic signed [ascl_pkg::COORD_W-1:0] x;
    logic signed [ascl_pkg::COORD_W-1:0] y;
    logic signed [ascl_pkg::COORD_W-1:0] z;
    logic [ascl_pkg::EL_W-1:0]           el;
    logic                                last;
  } atom_req_t;

  typedef struct packed {
    logic                        clash;
    logic                        overflow;
    logic [ascl_pkg::HELD_W-1:0] held;
  } clash_report_t;

  typedef struct {
    atom_req_t     req;
    int            reps;
    bit            typed;
    clash_report_t want;
  } stim_row_t;

  // DUT ports
  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic [ascl_pkg::MODE_W-1:0]         in_mode = '0;
  logic signed [ascl_pkg::COORD_W-1:0] in_pos_x = '0;
  logic signed [ascl_pkg::COORD_W-1:0] in_pos_y = '0;
  logic signed [ascl_pkg::COORD_W-1:0] in_pos_z = '0;
  logic [ascl_pkg::EL_W-1:0]           in_element = '0;
  logic                                in_last = 1'b0;
  logic                                out_valid;
  logic                                out_clash;
  logic                                out_overflow;
  logic [ascl_pkg::HELD_W-1:0]         out_held_atoms;

  // Predictor state
  int unsigned vdw_centi [8] = '{170, 155, 152, 109, 180, 0, 0, 0};
  atom_req_t   held_set [ascl_pkg::MAX_ATOMS];
  int          held_n = 0;
  bit          clash_acc = 1'b0;
  bit          dropped = 1'b0;

  clash_report_t reports_due [$];
  clash_report_t due;
  stim_row_t     stim_rows [$];
  int            fails = 0;
  int            items_sent = 0;
  int            idle_pct = 0;

  atom_set_clash_test DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_element     (in_element),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_clash      (out_clash),
    .out_overflow   (out_overflow),
    .out_held_atoms (out_held_atoms)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Exact hard-sphere test: d2 (2^-16 A^2) * 10000 < (ra + rb)^2 (0.01 A) * 65536
  function automatic bit pair_overlap(input atom_req_t p, input int k);
    longint            dx, dy, dz;
    longint unsigned   d2, rs;
    dx = longint'($signed(p.x)) - longint'($signed(held_set[k].x));
    dy = longint'($signed(p.y)) - longint'($signed(held_set[k].y));
    dz = longint'($signed(p.z)) - longint'($signed(held_set[k].z));
    d2 = dx * dx + dy * dy + dz * dz;
    rs = vdw_centi[p.el] + vdw_centi[held_set[k].el];
    return (d2 * 64'd10000) < (rs * rs * 64'd65536);
  endfunction

  // Advance predictor by one accepted request; returns 1 when a result is due
  function automatic bit model_request(input atom_req_t r, output clash_report_t rep);
    rep = '0;
    case (r.mode)
      ascl_pkg::MODE_CLEAR: begin
        held_n  = 0;
        dropped = 1'b0;
        return 1'b0;
      end
      ascl_pkg::MODE_LOAD: begin
        if (held_n < ascl_pkg::MAX_ATOMS) begin
          held_set[held_n] = r;
          held_n++;
        end else begin
          dropped = 1'b1;
        end
        return 1'b0;
      end
      ascl_pkg::MODE_PROBE: begin
        for (int k = 0; k < held_n; k++)
          if (pair_overlap(r, k)) clash_acc = 1'b1;
        if (!r.last) return 1'b0;
        rep.clash    = clash_acc;
        rep.overflow = dropped;
        rep.held     = held_n[ascl_pkg::HELD_W-1:0];
        clash_acc    = 1'b0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void add_row(input logic [ascl_pkg::MODE_W-1:0] mode, input int x,
                                  input int y, input int z,
                                  input logic [ascl_pkg::EL_W-1:0] el, input bit last,
                                  input int reps, input bit typed, input bit clash,
                                  input bit ovf, input int held);
    stim_row_t row;
    row.req.mode      = mode;
    row.req.x         = x[15:0];
    row.req.y         = y[15:0];
    row.req.z         = z[15:0];
    row.req.el        = el;
    row.req.last      = last;
    row.reps          = reps;
    row.typed         = typed;
    row.want.clash    = clash;
    row.want.overflow = ovf;
    row.want.held     = held[ascl_pkg::HELD_W-1:0];
    stim_rows.push_back(row);
  endfunction

  // Drive one request, wait for it to be taken, then maybe idle
  task automatic send(input atom_req_t r, input bit typed, input clash_report_t want);
    clash_report_t rep;
    bit            made;
    in_mode    <= r.mode;
    in_pos_x   <= r.x;
    in_pos_y   <= r.y;
    in_pos_z   <= r.z;
    in_element <= r.el;
    in_last    <= r.last;
    start      <= 1'b1;
    do @(posedge clk); while (busy === 1'b1);
    made = model_request(r, rep);
    if (made) reports_due.push_back(typed ? want : rep);
    if (r.mode != MODE_UNUSED) items_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic pause_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (reports_due.size() != 0);
  endtask

  // Mostly a compact cluster so sets overlap, sometimes anywhere
  function automatic logic [ascl_pkg::COORD_W-1:0] spread_coord();
    if ($urandom_range(0, 3) != 0) return 16'($urandom_range(0, 8191)) - 16'd4096;
    return 16'($urandom);
  endfunction

  function automatic atom_req_t random_item(input logic [ascl_pkg::MODE_W-1:0] mode);
    atom_req_t r;
    r.mode = mode;
    r.x    = 16'($urandom);
    r.y    = 16'($urandom);
    r.z    = 16'($urandom);
    r.el   = 3'($urandom_range(0, 7));
    r.last = 1'($urandom);
    return r;
  endfunction

  // One reference set followed by a few probe molecules, with some noise
  task automatic random_set();
    atom_req_t r;
    int        n_load, n_mol, n_at, k;
    if ($urandom_range(0, 49) == 0) begin
      send(random_item(ascl_pkg::MODE_CLEAR), 1'b0, '0);
      n_load = $urandom_range(240, 262);
    end else begin
      if (held_n > 48 || $urandom_range(0, 3) != 0)
        send(random_item(ascl_pkg::MODE_CLEAR), 1'b0, '0);
      n_load = $urandom_range(0, 10);
    end
    for (int i = 0; i < n_load; i++) begin
      r   = random_item(ascl_pkg::MODE_LOAD);
      r.x = spread_coord();
      r.y = spread_coord();
      r.z = spread_coord();
      send(r, 1'b0, '0);
    end
    n_mol = $urandom_range(1, 4);
    for (int m = 0; m < n_mol; m++) begin
      // noise: ignored modes, stray loads/clears, unmarked probes
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 3)) send(random_item(2'($urandom_range(0, 3))), 1'b0, '0);
      n_at = $urandom_range(1, 5);
      for (int a = 0; a < n_at; a++) begin
        r = random_item(ascl_pkg::MODE_PROBE);
        if (held_n > 0 && $urandom_range(0, 3) == 0) begin
          k   = $urandom_range(0, held_n - 1);
          r.x = held_set[k].x + 16'($urandom_range(0, 2000)) - 16'd1000;
          r.y = held_set[k].y + 16'($urandom_range(0, 2000)) - 16'd1000;
          r.z = held_set[k].z + 16'($urandom_range(0, 2000)) - 16'd1000;
        end else begin
          r.x = spread_coord();
          r.y = spread_coord();
          r.z = spread_coord();
        end
        r.last = (a == n_at - 1);
        if ($urandom_range(0, 9) == 0) r.last = 1'($urandom);
        send(r, 1'b0, '0);
      end
    end
  endtask

  // Result checker: every strobe must match the oldest pending request
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (reports_due.size() == 0) begin
        $error("result strobed with no request pending");
        fails++;
      end else begin
        due = reports_due.pop_front();
        if (out_clash !== due.clash) begin
          $error("clash: expected %0d, got %0d", due.clash, out_clash);
          fails++;
        end
        if (out_overflow !== due.overflow) begin
          $error("overflow: expected %0d, got %0d", due.overflow, out_overflow);
          fails++;
        end
        if (out_held_atoms !== due.held) begin
          $error("held_atoms: expected %0d, got %0d", due.held, out_held_atoms);
          fails++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int phase_idle [3];
    int base;
    phase_idle = '{16, 80, 0};

    //      mode                  x       y       z       el              last reps typed clash ovf held
    add_row(ascl_pkg::MODE_PROBE, 0,      0,      0,      ascl_pkg::EL_C, 1, 1,   1, 0, 0, 0);
    add_row(ascl_pkg::MODE_LOAD,  0,      0,      0,      ascl_pkg::EL_C, 1, 1,   0, 0, 0, 0);
    // C+S exactly touching is no clash, one LSB closer is
    add_row(ascl_pkg::MODE_PROBE, 896,    0,      0,      ascl_pkg::EL_S, 1, 1,   1, 0, 0, 1);
    add_row(ascl_pkg::MODE_PROBE, 0,      895,    0,      ascl_pkg::EL_S, 1, 1,   1, 1, 0, 1);
    // sticky over the molecule
    add_row(ascl_pkg::MODE_PROBE, 0,      0,      -600,   ascl_pkg::EL_C, 0, 1,   0, 0, 0, 0);
    add_row(ascl_pkg::MODE_PROBE, 32767,  32767,  32767,  ascl_pkg::EL_H, 1, 1,   1, 1, 0, 1);
    add_row(ascl_pkg::MODE_LOAD,  -32768, -32768, -32768, ascl_pkg::EL_S, 0, 1,   0, 0, 0, 0);
    add_row(ascl_pkg::MODE_LOAD,  32767,  -32768, 32767,  EL_UNK7,        0, 1,   0, 0, 0, 0);
    // two zero-radius atoms at the same spot never clash
    add_row(ascl_pkg::MODE_PROBE, 32767,  -32768, 32767,  EL_UNK6,        1, 1,   1, 0, 0, 3);
    add_row(ascl_pkg::MODE_PROBE, -32768, -32767, -32768, ascl_pkg::EL_N, 1, 1,   1, 1, 0, 3);
    add_row(MODE_UNUSED,          -1,     -1,     -1,     EL_UNK5,        1, 1,   0, 0, 0, 0);
    // clear keeps the pending clash flag
    add_row(ascl_pkg::MODE_PROBE, 0,      0,      0,      ascl_pkg::EL_O, 0, 1,   0, 0, 0, 0);
    add_row(ascl_pkg::MODE_CLEAR, 0,      0,      0,      ascl_pkg::EL_C, 1, 1,   0, 0, 0, 0);
    add_row(ascl_pkg::MODE_PROBE, 0,      0,      0,      ascl_pkg::EL_H, 1, 1,   1, 1, 0, 0);
    // fill the store and drop one
    add_row(ascl_pkg::MODE_LOAD,  -300,   700,    1000,   ascl_pkg::EL_O, 0, 257, 0, 0, 0, 0);
    add_row(ascl_pkg::MODE_PROBE, 10000,  10000,  10000,  ascl_pkg::EL_C, 1, 1,   1, 0, 1, 256);
    add_row(ascl_pkg::MODE_PROBE, -300,   700,    1000,   ascl_pkg::EL_O, 1, 1,   1, 1, 1, 256);
    add_row(ascl_pkg::MODE_LOAD,  5,      5,      5,      ascl_pkg::EL_C, 0, 1,   0, 0, 0, 0);
    add_row(ascl_pkg::MODE_CLEAR, -1,     -1,     -1,     EL_UNK7,        0, 1,   0, 0, 0, 0);
    add_row(ascl_pkg::MODE_PROBE, -32768, 32767,  0,      ascl_pkg::EL_S, 1, 1,   1, 0, 0, 0);
    add_row(ascl_pkg::MODE_LOAD,  12345,  -4321,  77,     ascl_pkg::EL_N, 0, 1,   0, 0, 0, 0);
    add_row(ascl_pkg::MODE_LOAD,  12600,  -4200,  300,    ascl_pkg::EL_H, 0, 1,   0, 0, 0, 0);
    add_row(ascl_pkg::MODE_PROBE, 12400,  -4300,  100,    EL_UNK5,        0, 1,   0, 0, 0, 0);
    add_row(ascl_pkg::MODE_PROBE, 12420,  -4310,  90,     ascl_pkg::EL_H, 1, 1,   0, 0, 0, 0);
    add_row(ascl_pkg::MODE_PROBE, 12900,  -3900,  700,    ascl_pkg::EL_S, 1, 1,   0, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    idle_pct = phase_idle[0];
    foreach (stim_rows[i])
      repeat (stim_rows[i].reps) send(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);

    // random phases with different sender idling, filling up to the item goal
    base = items_sent;
    for (int p = 0; p < 3; p++) begin
      pause_until_drained();
      idle_pct = phase_idle[p];
      while (items_sent < base + (ITEM_GOAL - base) * (p + 1) / 3) random_set();
    end

    // drain
    start <= 1'b0;
    do @(posedge clk); while (reports_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
